@@ sv/ptt_pkg.sv @@
// ----------------------------------------------------------------------------
// ptt_pkg
// shared types and command codes of the periodic task timer table
// ----------------------------------------------------------------------------
package ptt_pkg;

    localparam logic [2:0] CMD_TICK     = 3'd0;
    localparam logic [2:0] CMD_REGISTER = 3'd1;
    localparam logic [2:0] CMD_UNREG_ID = 3'd2;
    localparam logic [2:0] CMD_UNREG_PAR = 3'd3;
    localparam logic [2:0] CMD_CHANGE   = 3'd4;
    localparam logic [2:0] CMD_QUERY_ID = 3'd5;
    localparam logic [2:0] CMD_QUERY_PAR = 3'd6;
    localparam logic [2:0] CMD_UNUSED   = 3'd7;

    localparam int ENTRY_W  = 65;
    localparam int RESULT_W = 32;

    // controller to datapath
    typedef struct packed {
        logic latch;
        logic rd;
        logic proc;
        logic fin;
        logic one;
        logic erd;
        logic eld;
    } ctrl_t;

    // datapath to controller
    typedef struct packed {
        logic start_walk;
        logic walk_done;
        logic any_fired;
        logic emit_done;
        logic out_busy;
    } stat_t;

endpackage

@@ sv/ptt_ram.sv @@
// ----------------------------------------------------------------------------
// ptt_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module ptt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ sv/ptt_ctrl.sv @@
// ----------------------------------------------------------------------------
// ptt_ctrl
// command sequencer: accept, table walk, finish, result emission
// ----------------------------------------------------------------------------
module ptt_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  ptt_pkg::stat_t stat,
    output ptt_pkg::ctrl_t ctrl
);
    import ptt_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_PROC = 3'd2;
    localparam logic [2:0] S_FIN  = 3'd3;
    localparam logic [2:0] S_ONE  = 3'd4;
    localparam logic [2:0] S_ERD  = 3'd5;
    localparam logic [2:0] S_ELD  = 3'd6;
    localparam logic [2:0] S_WAIT = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctrl.latch = 1'b1;
                    state_next = stat.start_walk ? S_RD : S_FIN;
                end
            end
            S_RD:
            begin
                if (stat.walk_done)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    ctrl.rd    = 1'b1;
                    state_next = S_PROC;
                end
            end
            S_PROC:
            begin
                ctrl.proc  = 1'b1;
                state_next = S_RD;
            end
            S_FIN:
            begin
                ctrl.fin   = 1'b1;
                state_next = stat.any_fired ? S_ERD : S_ONE;
            end
            S_ONE:
            begin
                ctrl.one   = 1'b1;
                state_next = S_WAIT;
            end
            S_ERD:
            begin
                ctrl.erd   = 1'b1;
                state_next = S_ELD;
            end
            S_ELD:
            begin
                ctrl.eld   = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (!stat.out_busy)
                begin
                    state_next = stat.emit_done ? S_IDLE : S_ERD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ sv/ptt_dp.sv @@
// ----------------------------------------------------------------------------
// ptt_dp
// task table datapath: entry ram, compaction walk, fire buffer, output register
// ----------------------------------------------------------------------------
module ptt_dp #(
    parameter int MAX_TASKS = 16,
    localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1,
    localparam int CW = $clog2(MAX_TASKS + 1)
) (
    input  logic           clk,
    input  logic           rst_n,
    input  ptt_pkg::ctrl_t ctrl,
    output ptt_pkg::stat_t stat,
    input  logic [2:0]     in_cmd,
    input  logic [15:0]    in_id,
    input  logic [15:0]    in_param,
    input  logic [15:0]    in_interval,
    input  logic           in_persistent,
    input  logic           cfg_valid,
    input  logic           cfg_data,
    output logic           out_valid,
    input  logic           out_ready,
    output logic           out_fired,
    output logic [15:0]    out_id,
    output logic [15:0]    out_param,
    output logic           out_ok,
    output logic [4:0]     out_count,
    output logic           out_last
);
    import ptt_pkg::*;

    logic          run_en_reg;
    logic [CW-1:0] used_reg, src_reg, dst_reg, nf_reg, em_reg;
    logic          found_reg, walk_reg, ok_reg;
    logic [2:0]    cmd_reg;
    logic [15:0]   id_reg, param_reg, ivl_reg;

    logic               ent_we;
    logic [AW-1:0]      ent_waddr;
    logic [ENTRY_W-1:0] ent_wdata, ent_rdata;
    logic               res_we;
    logic [RESULT_W-1:0] res_rdata;

    logic        e_rep;
    logic [15:0] e_id, e_param, e_ivl, e_tick;
    logic        keep, fire, match, reg_ok;
    logic [15:0] new_tick, new_ivl;

    logic        out_valid_reg, out_fired_reg, out_ok_reg, out_last_reg;
    logic [15:0] out_id_reg, out_param_reg;
    logic [4:0]  out_count_reg;

    assign {e_rep, e_tick, e_ivl, e_param, e_id} = ent_rdata;

    assign reg_ok = (in_cmd == CMD_REGISTER) && (in_id != 16'd0)
                    && (used_reg < CW'(MAX_TASKS));

    always_comb
    begin
        fire     = 1'b0;
        match    = 1'b0;
        keep     = 1'b1;
        new_tick = e_tick;
        new_ivl  = e_ivl;
        case (cmd_reg)
            CMD_TICK:
            begin
                fire     = (e_tick >= e_ivl);
                new_tick = fire ? 16'd0 : e_tick + 16'd1;
                keep     = !(fire && !e_rep);
            end
            CMD_UNREG_ID:
            begin
                match = !found_reg && (id_reg != 16'd0) && (e_id == id_reg);
                keep  = !match;
            end
            CMD_UNREG_PAR:
            begin
                match = !found_reg && (e_param == param_reg);
                keep  = !match;
            end
            CMD_CHANGE:
            begin
                match = !found_reg && (id_reg != 16'd0) && (e_id == id_reg);
                if (match)
                begin
                    new_ivl = ivl_reg;
                end
            end
            CMD_QUERY_ID:
            begin
                match = !found_reg && (id_reg != 16'd0) && (e_id == id_reg);
            end
            CMD_QUERY_PAR:
            begin
                match = !found_reg && (e_param == param_reg);
            end
            default:
            begin
                keep = 1'b1;
            end
        endcase
    end

    // register writes straight at the tail, the walk writes compacted at dst
    always_comb
    begin
        if (ctrl.latch)
        begin
            ent_we    = reg_ok;
            ent_waddr = used_reg[AW-1:0];
            ent_wdata = {in_persistent, 16'd0, in_interval, in_param, in_id};
        end
        else
        begin
            ent_we    = ctrl.proc && keep;
            ent_waddr = dst_reg[AW-1:0];
            ent_wdata = {e_rep, new_tick, new_ivl, e_param, e_id};
        end
    end

    assign res_we = ctrl.proc && fire;

    ptt_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_TASKS)) u_entry_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .raddr (src_reg[AW-1:0]),
        .rdata (ent_rdata)
    );

    ptt_ram #(.WIDTH(RESULT_W), .DEPTH(MAX_TASKS)) u_fire_ram (
        .clk   (clk),
        .we    (res_we),
        .waddr (nf_reg[AW-1:0]),
        .wdata ({e_param, e_id}),
        .raddr (em_reg[AW-1:0]),
        .rdata (res_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_en_reg    <= 1'b1;
            used_reg      <= '0;
            src_reg       <= '0;
            dst_reg       <= '0;
            nf_reg        <= '0;
            em_reg        <= '0;
            found_reg     <= 1'b0;
            walk_reg      <= 1'b0;
            ok_reg        <= 1'b0;
            cmd_reg       <= CMD_TICK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                run_en_reg <= cfg_data;
            end
            if (ctrl.latch)
            begin
                cmd_reg   <= in_cmd;
                src_reg   <= '0;
                dst_reg   <= '0;
                nf_reg    <= '0;
                em_reg    <= '0;
                found_reg <= 1'b0;
                walk_reg  <= stat.start_walk;
                ok_reg    <= reg_ok;
                if (reg_ok)
                begin
                    used_reg <= used_reg + CW'(1);
                end
            end
            if (ctrl.proc)
            begin
                src_reg <= src_reg + CW'(1);
                if (keep)
                begin
                    dst_reg <= dst_reg + CW'(1);
                end
                if (fire)
                begin
                    nf_reg <= nf_reg + CW'(1);
                end
                if (match)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (ctrl.fin && walk_reg)
            begin
                used_reg <= dst_reg;
                ok_reg   <= (cmd_reg == CMD_TICK) ? 1'b1 : found_reg;
            end
            if (ctrl.eld)
            begin
                em_reg <= em_reg + CW'(1);
            end
            if (ctrl.one || ctrl.eld)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.latch)
        begin
            id_reg    <= in_id;
            param_reg <= in_param;
            ivl_reg   <= in_interval;
        end
        if (ctrl.one)
        begin
            out_fired_reg <= 1'b0;
            out_id_reg    <= 16'd0;
            out_param_reg <= 16'd0;
            out_ok_reg    <= ok_reg;
            out_count_reg <= 5'(used_reg);
            out_last_reg  <= 1'b1;
        end
        else if (ctrl.eld)
        begin
            out_fired_reg <= 1'b1;
            out_id_reg    <= res_rdata[15:0];
            out_param_reg <= res_rdata[31:16];
            out_ok_reg    <= ok_reg;
            out_count_reg <= 5'(used_reg);
            out_last_reg  <= ((em_reg + CW'(1)) == nf_reg);
        end
    end

    // a walk runs for ticks while enabled and for every search command
    assign stat.start_walk = ((in_cmd == CMD_TICK) && run_en_reg)
                             || (in_cmd == CMD_UNREG_ID) || (in_cmd == CMD_UNREG_PAR)
                             || (in_cmd == CMD_CHANGE) || (in_cmd == CMD_QUERY_ID)
                             || (in_cmd == CMD_QUERY_PAR);
    assign stat.walk_done  = (src_reg == used_reg);
    assign stat.any_fired  = (nf_reg != '0);
    assign stat.emit_done  = (em_reg == nf_reg);
    assign stat.out_busy   = out_valid_reg;

    assign out_valid = out_valid_reg;
    assign out_fired = out_fired_reg;
    assign out_id    = out_id_reg;
    assign out_param = out_param_reg;
    assign out_ok    = out_ok_reg;
    assign out_count = out_count_reg;
    assign out_last  = out_last_reg;

endmodule

@@ sv/periodic_task_timer_table_unit.sv @@
// ----------------------------------------------------------------------------
// periodic_task_timer_table_unit
// compact table of timed tasks with register, remove, change, query and tick
//
//   channel   direction  payload
//   s_axis    in         command beat: cmd, id, param, interval, persistent
//   m_axis    out        result beat: fired, id, param, ok, count; tlast ends
//   cfg       in         run_enable
//
// register, unused codes and ticks with run_enable low skip the walk and
// give one non-firing result beat. every other command walks the entry ram,
// reading then processing each stored task, then gives one beat per fired
// result, or a single non-firing beat when none fired.
// reset empties the table and sets run_enable; no clearing pass is needed.
// a stalled m_axis holds the result; s_axis is ready again once the last
// beat has been taken.
// ----------------------------------------------------------------------------
module periodic_task_timer_table_unit #(
    parameter int MAX_TASKS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // cmd[2:0], task_id[18:3], task_param[34:19], task_interval[50:35],
    // persistent[51], zero fill
    input  logic [55:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // fired_id[15:0], fired_param[31:16], ok[32], entry_count[37:33], zero fill
    output logic [39:0] m_axis_tdata,
    // fired[0]
    output logic        m_axis_tuser,
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);
    import ptt_pkg::*;

    ctrl_t       ctrl;
    stat_t       stat;
    logic        o_ok;
    logic [4:0]  o_count;
    logic [15:0] o_id, o_param;

    assign cfg_ready = 1'b1;

    ptt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    ptt_dp #(.MAX_TASKS(MAX_TASKS)) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .stat          (stat),
        .in_cmd        (s_axis_tdata[2:0]),
        .in_id         (s_axis_tdata[18:3]),
        .in_param      (s_axis_tdata[34:19]),
        .in_interval   (s_axis_tdata[50:35]),
        .in_persistent (s_axis_tdata[51]),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_fired     (m_axis_tuser),
        .out_id        (o_id),
        .out_param     (o_param),
        .out_ok        (o_ok),
        .out_count     (o_count),
        .out_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, o_count, o_ok, o_param, o_id};

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("result pending while accepting commands");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("ready again right after a command");

    a_fired_id: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[15:0] != 16'd0)
        else $error("fired task with id zero");

    a_idle_result: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
        else $error("non-firing result not marked last");

endmodule
